[src/ryc_pkg.sv]
// ----------------------------------------------------------------------------
// Colour converter package
// Shared types, widths and constants for the per-pixel 3x3 matrix converter.
// ----------------------------------------------------------------------------
package ryc_pkg;

  localparam int unsigned CompW  = 8;
  localparam int unsigned CoefW  = 16;
  localparam int unsigned RowW   = 3 * CoefW;
  localparam int unsigned OpndW  = CompW + 1;
  localparam int unsigned ProdW  = OpndW + CoefW;
  localparam int unsigned FracW  = 13;
  localparam int unsigned NumCh  = 3;

  localparam logic [CompW-1:0] PlaneOff [NumCh] = '{8'd16, 8'd128, 8'd128};

  typedef enum logic [1:0] {
    REG_DIRECTION     = 2'd0,
    REG_COEF_ROW_ZERO = 2'd1,
    REG_COEF_ROW_ONE  = 2'd2,
    REG_COEF_ROW_TWO  = 2'd3
  } cfg_reg_e;

  typedef logic signed [OpndW-1:0] opnd_t;

  typedef struct packed {
    logic [CompW-1:0] comp_a;
    logic [CompW-1:0] comp_b;
    logic [CompW-1:0] comp_c;
    logic             chroma_site;
  } pixel_t;

  typedef struct packed {
    logic [CompW-1:0] out_a;
    logic [CompW-1:0] out_b;
    logic [CompW-1:0] out_c;
    logic             chroma_valid;
  } result_t;

  typedef struct packed {
    logic en;
    logic inverse;
  } lane_ctrl_t;

  typedef struct packed {
    logic valid;
    logic inverse;
    logic site;
  } stage_ctrl_t;

endpackage

[src/ryc_lane.sv]
// ----------------------------------------------------------------------------
// Colour converter lane
// One output channel: three registered products, then truncation of each
// plus offset (forward) or sum then truncation (inverse), and clamp.
// ----------------------------------------------------------------------------
module ryc_lane import ryc_pkg::*; (
  input  logic             clk_i,
  input  lane_ctrl_t       ctrl_i,
  input  opnd_t            opnd_i [NumCh],
  input  logic [RowW-1:0]  coef_i,
  input  logic [CompW-1:0] offset_i,
  output logic [CompW-1:0] value_o
);

  localparam int unsigned TrW  = ProdW - FracW;
  localparam int unsigned AccW = TrW + 3;
  localparam int unsigned SumW = ProdW + 2;
  localparam int unsigned ItrW = SumW - FracW;

  logic signed [ProdW-1:0] prod_d [NumCh];
  logic signed [ProdW-1:0] prod_q [NumCh];
  logic                    inverse_q;

  always_comb begin
    for (int k = 0; k < NumCh; k++) begin
      prod_d[k] = ProdW'(opnd_i[k] * $signed(coef_i[k*CoefW +: CoefW]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      prod_q    <= prod_d;
      inverse_q <= ctrl_i.inverse;
    end
  end

  logic signed [ProdW-1:0] biased [NumCh];
  logic signed [AccW-1:0]  fwd_acc;
  logic signed [SumW-1:0]  inv_sum;
  logic signed [SumW-1:0]  inv_biased;
  logic signed [AccW-1:0]  acc;

  always_comb begin
    fwd_acc = $signed({{(AccW-CompW){1'b0}}, offset_i});
    inv_sum = '0;
    for (int k = 0; k < NumCh; k++) begin
      biased[k] = prod_q[k] + (prod_q[k][ProdW-1] ? ProdW'((1 << FracW) - 1) : ProdW'(0));
      fwd_acc   = fwd_acc + $signed({{3{biased[k][ProdW-1]}}, biased[k][ProdW-1:FracW]});
      inv_sum   = inv_sum + $signed({{2{prod_q[k][ProdW-1]}}, prod_q[k]});
    end
    inv_biased = inv_sum + (inv_sum[SumW-1] ? SumW'((1 << FracW) - 1) : SumW'(0));
    if (inverse_q) begin
      acc = $signed({{(AccW-ItrW){inv_biased[SumW-1]}}, inv_biased[SumW-1:FracW]});
    end else begin
      acc = fwd_acc;
    end
    if (acc < 0) begin
      value_o = '0;
    end else if (acc > $signed(AccW'(255))) begin
      value_o = '1;
    end else begin
      value_o = acc[CompW-1:0];
    end
  end

endmodule

[src/rgb_yuv420_color_converter.sv]
// ----------------------------------------------------------------------------
// RGB / YUV 4:2:0 colour converter
// Per-pixel 3x3 matrix conversion with three parallel channel lanes and a
// merging output register that applies chroma site gating.
// ----------------------------------------------------------------------------
//   Channel   Ports                                  Handshake
//   pixel     start_i, busy_o, pix_i                 start_i && !busy_o
//   result    res_valid_o, res_o                     strobe, one cycle
//   config    cfg_we_i, cfg_idx_i, cfg_wdata_i       cfg_we_i
//
// One pixel transaction is accepted every clock cycle; busy_o is never high.
// Each pixel passes through the lane product registers, then the merged output
// register. Reset clears the configuration and all valid flags.
// The receiver cannot stall, so each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module rgb_yuv420_color_converter import ryc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  pixel_t           pix_i,
  output logic             res_valid_o,
  output result_t          res_o,
  input  logic             cfg_we_i,
  input  cfg_reg_e         cfg_idx_i,
  input  logic [RowW-1:0]  cfg_wdata_i
);

  logic            direction_q;
  logic [RowW-1:0] coef_q [NumCh];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q <= 1'b0;
      coef_q      <= '{default: '0};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DIRECTION:     direction_q <= cfg_wdata_i[0];
        REG_COEF_ROW_ZERO: coef_q[0]   <= cfg_wdata_i;
        REG_COEF_ROW_ONE:  coef_q[1]   <= cfg_wdata_i;
        REG_COEF_ROW_TWO:  coef_q[2]   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  logic       accept;
  logic [CompW-1:0] comp [NumCh];
  opnd_t      opnd [NumCh];
  lane_ctrl_t lane_ctrl;
  logic [CompW-1:0] lane_val [NumCh];

  assign accept  = start_i && !busy_o;
  assign comp[0] = pix_i.comp_a;
  assign comp[1] = pix_i.comp_b;
  assign comp[2] = pix_i.comp_c;

  always_comb begin
    for (int k = 0; k < NumCh; k++) begin
      if (direction_q) begin
        opnd[k] = $signed({1'b0, comp[k]}) - $signed({1'b0, PlaneOff[k]});
      end else begin
        opnd[k] = $signed({1'b0, comp[k]});
      end
    end
  end

  assign lane_ctrl = '{en: accept, inverse: direction_q};

  for (genvar g = 0; g < NumCh; g++) begin : g_lane
    ryc_lane u_lane (
      .clk_i    (clk_i),
      .ctrl_i   (lane_ctrl),
      .opnd_i   (opnd),
      .coef_i   (coef_q[g]),
      .offset_i (PlaneOff[g]),
      .value_o  (lane_val[g])
    );
  end

  stage_ctrl_t st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= '{valid: accept, inverse: direction_q, site: pix_i.chroma_site};
    end
  end

  logic    res_valid_q;
  result_t res_d;
  result_t res_q;
  logic    chroma_keep;

  assign chroma_keep = st_q.inverse || st_q.site;

  always_comb begin
    res_d.out_a        = lane_val[0];
    res_d.out_b        = chroma_keep ? lane_val[1] : '0;
    res_d.out_c        = chroma_keep ? lane_val[2] : '0;
    res_d.chroma_valid = chroma_keep;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= st_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q.valid) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##2 res_valid_o)
    else $error("Accepted transaction did not give a result after two cycles.");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start_i |-> ##2 !res_valid_o)
    else $error("Result strobe without an accepted transaction.");

  a_chroma_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.chroma_valid) |-> (res_o.out_b == '0 && res_o.out_c == '0))
    else $error("Chroma outputs not cleared off a chroma site.");

  a_inverse_chroma: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && direction_q) |-> ##2 res_o.chroma_valid)
    else $error("Inverse transaction gave a result without chroma.");

endmodule
